[src/sfq_pkg.sv]
// ----------------------------------------------------------------------------
// sfq_pkg
// Shared types and constants for the searchable FIFO queue: item layouts,
// operation and status codes, cell control bundle and controller states.
// ----------------------------------------------------------------------------
package sfq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int WORD_W          = 32;
  localparam int MODE_W          = 2;
  localparam int STATUS_W        = 2;
  localparam int OCC_W           = 5;

  localparam logic [MODE_W-1:0] MODE_ENQ  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DEQ  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SRCH = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0]        mode;
    logic signed [WORD_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] data_out;
    logic [STATUS_W-1:0]      status;
    logic                     found;
    logic [OCC_W-1:0]         occupancy;
  } out_item_t;

  typedef struct packed {
    logic                     shift;
    logic                     push;
    logic                     cmp;
    logic signed [WORD_W-1:0] key;
  } cell_ctl_t;

  typedef enum logic {
    S_IDLE,
    S_SEARCH
  } sfq_state_t;

endpackage

[src/sfq_cell.sv]
// ----------------------------------------------------------------------------
// sfq_cell
// One queue position: holds a word and its valid bit, takes the word of the
// cell above on a dequeue, loads on an enqueue when it is the first free
// position, and registers a local compare against the search key.
// ----------------------------------------------------------------------------
module sfq_cell (
  input  logic                             clk,
  input  logic                             rst_n,
  input  sfq_pkg::cell_ctl_t               ctl,
  input  logic signed [sfq_pkg::WORD_W-1:0] up_word,
  input  logic                             up_valid,
  input  logic                             down_valid,
  output logic signed [sfq_pkg::WORD_W-1:0] word,
  output logic                             valid,
  output logic                             match
);
  import sfq_pkg::*;

  logic signed [WORD_W-1:0] word_r, word_nxt;
  logic                     valid_r, valid_nxt;
  logic                     match_r, match_nxt;

  always_comb begin
    word_nxt  = word_r;
    valid_nxt = valid_r;
    match_nxt = match_r;
    if (ctl.shift) begin
      word_nxt  = up_word;
      valid_nxt = up_valid;
    end else if (ctl.push && !valid_r && down_valid) begin
      word_nxt  = ctl.key;
      valid_nxt = 1'b1;
    end
    if (ctl.cmp) begin
      match_nxt = valid_r && (word_r == ctl.key);
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
      match_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      match_r <= match_nxt;
    end
  end

  assign word  = word_r;
  assign valid = valid_r;
  assign match = match_r;

endmodule

[src/searchable_fifo_queue_top.sv]
// ----------------------------------------------------------------------------
// searchable_fifo_queue_top
// FIFO queue of signed words with membership search, built as a row of cells
// with the oldest word in cell 0.
//
//   channel | ports                      | item
//   --------+----------------------------+-------------------------------------
//   input   | in_valid, in_stall, in_data   | mode, value
//   result  | out_valid, out_stall, out_data| data_out, status, found, occupancy
//
// Enqueue, dequeue and the unused mode load their result into the output
// register; in a search the cells register their compare, then the match
// bits are ORed into the result. One item is in work at a time. Outside a
// search, a new item enters in the same cycle that a waiting result is taken.
// A synchronous reset empties the queue. A stalled result stalls input, and
// holds the controller in the search step when a search is in work.
// ----------------------------------------------------------------------------
module searchable_fifo_queue_top #(
  parameter int QUEUE_DEPTH = sfq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  sfq_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output sfq_pkg::out_item_t out_data
);
  import sfq_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic signed [WORD_W-1:0] word_w [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]   valid_w;
  logic [QUEUE_DEPTH-1:0]   match_w;
  cell_ctl_t                ctl;

  sfq_state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r;
  out_item_t        res;
  logic             load_out;
  logic             accept, is_enq, is_deq, is_srch, full, empty, out_free;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic signed [WORD_W-1:0] up_word;
    logic                     up_valid;
    logic                     down_valid;
    if (i == QUEUE_DEPTH - 1) begin : g_top
      assign up_word  = '0;
      assign up_valid = 1'b0;
    end else begin : g_mid
      assign up_word  = word_w[i+1];
      assign up_valid = valid_w[i+1];
    end
    if (i == 0) begin : g_head
      assign down_valid = 1'b1;
    end else begin : g_rest
      assign down_valid = valid_w[i-1];
    end
    sfq_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .up_word   (up_word),
      .up_valid  (up_valid),
      .down_valid(down_valid),
      .word      (word_w[i]),
      .valid     (valid_w[i]),
      .match     (match_w[i])
    );
  end

  assign is_enq   = (in_data.mode == MODE_ENQ);
  assign is_deq   = (in_data.mode == MODE_DEQ);
  assign is_srch  = (in_data.mode == MODE_SRCH);
  assign full     = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign empty    = (cnt_r == '0);
  assign out_free = !(out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    ctl.shift = accept && is_deq && !empty;
    ctl.push  = accept && is_enq && !full;
    ctl.cmp   = accept && is_srch;
    ctl.key   = in_data.value;
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (ctl.push) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (ctl.shift) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && is_srch) state_nxt = S_SEARCH;
      end
      S_SEARCH: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall           = 1'b1;
    load_out           = 1'b0;
    res.data_out       = '0;
    res.status         = STAT_DONE;
    res.found          = 1'b0;
    res.occupancy      = OCC_W'(cnt_nxt);
    case (state_r)
      S_IDLE: begin
        in_stall = !out_free;
        load_out = accept && !is_srch;
        if (is_deq) begin
          if (empty) res.status = STAT_EMPTY;
          else       res.data_out = word_w[0];
        end else if (is_enq && full) begin
          res.status = STAT_FULL;
        end
      end
      S_SEARCH: begin
        load_out      = out_free;
        res.found     = |match_w;
        res.occupancy = OCC_W'(cnt_r);
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) out_data_r <= res;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_valid_count : assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_w) == int'(cnt_r))
    else $error("cell valid bits disagree with occupancy count");

  a_valid_packed : assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(valid_w & ~(valid_w << 1)) && (valid_w[0] || valid_w == '0))
    else $error("occupied cells are not contiguous from the head");

  a_push_count : assert property (@(posedge clk) disable iff (!rst_n)
    ctl.push |=> cnt_r == $past(cnt_r) + CNT_W'(1))
    else $error("enqueue did not advance occupancy");

  a_search_done : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEARCH && load_out) |-> res.status == STAT_DONE)
    else $error("search result carries an error status");

endmodule
